/* rtl/ubd_pkg.sv */
// shared types, constants and beep pattern table for the unlock pulse burst decoder
`timescale 1ns / 1ps

package ubd_pkg;

    // field and state widths
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned BEEP_W = 2;
    localparam int unsigned LEN_W  = 9;
    localparam int unsigned FLAG_W = 3;
    localparam int unsigned EVT_W  = 2;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_QUIET_GAP = 2'd1;
    localparam logic [1:0] REG_MAX_BURST = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd150;
    localparam logic [CFG_W-1:0] QUIET_GAP_RST = 16'd1500;
    localparam logic [CFG_W-1:0] MAX_BURST_RST = 16'd10000;

    // toggle event codes
    localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVT_W-1:0] EVT_LOCK  = 2'd1;
    localparam logic [EVT_W-1:0] EVT_START = 2'd2;
    localparam logic [EVT_W-1:0] EVT_AUTO  = 2'd3;

    // burst lengths that select a flag
    localparam logic [CNT_W-1:0] CNT_LOCK  = 8'd3;
    localparam logic [CNT_W-1:0] CNT_START = 8'd4;
    localparam logic [CNT_W-1:0] CNT_AUTO  = 8'd5;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] quiet_gap;
        logic [CFG_W-1:0] max_burst;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [BEEP_W-1:0] beeps;
        logic [LEN_W-1:0]  on_len;
        logic [LEN_W-1:0]  off_len;
    } t_pat_req;

    // beep pattern for a toggle event, given the flag value after the toggle
    function automatic t_pat_req pattern_for(input logic [EVT_W-1:0] evt, input logic set);
        t_pat_req p;
        p = '0;
        case (evt)
            EVT_LOCK: begin
                p.start   = 1'b1;
                p.beeps   = set ? 2'd2 : 2'd1;
                p.on_len  = set ? 9'd200 : 9'd300;
                p.off_len = set ? 9'd200 : 9'd0;
            end
            EVT_START: begin
                p.start   = 1'b1;
                p.beeps   = set ? 2'd3 : 2'd1;
                p.on_len  = set ? 9'd200 : 9'd400;
                p.off_len = set ? 9'd200 : 9'd0;
            end
            EVT_AUTO: begin
                p.start   = 1'b1;
                p.beeps   = set ? 2'd2 : 2'd1;
                p.on_len  = set ? 9'd150 : 9'd350;
                p.off_len = set ? 9'd150 : 9'd0;
            end
            default: begin
                p = '0;
            end
        endcase
        return p;
    endfunction

endpackage

/* rtl/ubd_cfg.sv */
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module ubd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ubd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ubd_pkg::DATA_W-1:0]   pwdata,
    output logic [ubd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output ubd_pkg::t_cfg                o_cfg
);

    ubd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes, data truncated to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= ubd_pkg::DEBOUNCE_RST;
            r_cfg.quiet_gap <= ubd_pkg::QUIET_GAP_RST;
            r_cfg.max_burst <= ubd_pkg::MAX_BURST_RST;
        end else if (wr_en) begin
            case (reg_idx)
                ubd_pkg::REG_DEBOUNCE:  r_cfg.debounce  <= pwdata[ubd_pkg::CFG_W-1:0];
                ubd_pkg::REG_QUIET_GAP: r_cfg.quiet_gap <= pwdata[ubd_pkg::CFG_W-1:0];
                ubd_pkg::REG_MAX_BURST: r_cfg.max_burst <= pwdata[ubd_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            ubd_pkg::REG_DEBOUNCE:
                prdata = {{(ubd_pkg::DATA_W-ubd_pkg::CFG_W){1'b0}}, r_cfg.debounce};
            ubd_pkg::REG_QUIET_GAP:
                prdata = {{(ubd_pkg::DATA_W-ubd_pkg::CFG_W){1'b0}}, r_cfg.quiet_gap};
            ubd_pkg::REG_MAX_BURST:
                prdata = {{(ubd_pkg::DATA_W-ubd_pkg::CFG_W){1'b0}}, r_cfg.max_burst};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/ubd_pulse.sv */
// pulse counting, burst evaluation and flag toggling
`timescale 1ns / 1ps

module ubd_pulse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  ubd_pkg::t_cfg                 i_cfg,
    input  logic [ubd_pkg::TIME_W-1:0]    i_now,
    input  logic                          i_pin,
    input  logic                          i_mon,
    output ubd_pkg::t_pat_req             o_req,
    output logic [ubd_pkg::EVT_W-1:0]     o_event,
    output logic [ubd_pkg::FLAG_W-1:0]    o_flags
);

    logic                          r_prior;
    logic [ubd_pkg::TIME_W-1:0]    r_last_edge;
    logic [ubd_pkg::TIME_W-1:0]    r_first;
    logic [ubd_pkg::TIME_W-1:0]    r_last;
    logic [ubd_pkg::CNT_W-1:0]     r_cnt;
    logic [ubd_pkg::FLAG_W-1:0]    r_flags;

    logic                          n_prior;
    logic [ubd_pkg::TIME_W-1:0]    n_last_edge;
    logic [ubd_pkg::TIME_W-1:0]    n_first;
    logic [ubd_pkg::TIME_W-1:0]    n_last;
    logic [ubd_pkg::CNT_W-1:0]     n_cnt;
    logic [ubd_pkg::FLAG_W-1:0]    n_flags;

    logic [ubd_pkg::TIME_W-1:0]    d_edge;
    logic [ubd_pkg::TIME_W-1:0]    d_quiet;
    logic [ubd_pkg::TIME_W-1:0]    d_span;
    logic                          edge_ok;
    logic                          eval;
    logic [ubd_pkg::CNT_W-1:0]     cnt_a;
    logic [ubd_pkg::TIME_W-1:0]    first_a;
    logic [ubd_pkg::TIME_W-1:0]    last_a;
    logic [ubd_pkg::EVT_W-1:0]     evt;
    logic [ubd_pkg::FLAG_W-1:0]    tgl_mask;

    // debounced rising edge
    assign d_edge  = i_now - r_last_edge;
    assign edge_ok = i_mon && i_pin && !r_prior &&
                     (d_edge >= {{(ubd_pkg::TIME_W-ubd_pkg::CFG_W){1'b0}}, i_cfg.debounce});

    // pulse bookkeeping after the edge
    assign cnt_a   = edge_ok ? r_cnt + 8'd1 : r_cnt;
    assign first_a = (edge_ok && (r_cnt == '0)) ? i_now : r_first;
    assign last_a  = edge_ok ? i_now : r_last;

    // burst evaluation once the line has gone quiet
    assign d_quiet = i_now - last_a;
    assign d_span  = last_a - first_a;
    assign eval    = i_mon && (cnt_a != '0) &&
                     (d_quiet >= {{(ubd_pkg::TIME_W-ubd_pkg::CFG_W){1'b0}}, i_cfg.quiet_gap});

    always_comb begin
        evt = ubd_pkg::EVT_NONE;
        if (eval && (d_span <= {{(ubd_pkg::TIME_W-ubd_pkg::CFG_W){1'b0}}, i_cfg.max_burst})) begin
            case (cnt_a)
                ubd_pkg::CNT_LOCK:  evt = ubd_pkg::EVT_LOCK;
                ubd_pkg::CNT_START: evt = ubd_pkg::EVT_START;
                ubd_pkg::CNT_AUTO:  evt = ubd_pkg::EVT_AUTO;
                default:            evt = ubd_pkg::EVT_NONE;
            endcase
        end
    end

    // flag toggle
    always_comb begin
        case (evt)
            ubd_pkg::EVT_LOCK:  tgl_mask = 3'b001;
            ubd_pkg::EVT_START: tgl_mask = 3'b010;
            ubd_pkg::EVT_AUTO:  tgl_mask = 3'b100;
            default:            tgl_mask = 3'b000;
        endcase
    end

    assign n_flags = r_flags ^ tgl_mask;
    assign o_req   = ubd_pkg::pattern_for(evt, |(n_flags & tgl_mask));
    assign o_event = evt;
    assign o_flags = n_flags;

    // next state, frozen while monitoring is off
    assign n_prior     = i_mon ? i_pin : r_prior;
    assign n_last_edge = edge_ok ? i_now : r_last_edge;
    assign n_cnt       = eval ? '0 : cnt_a;
    assign n_first     = eval ? '0 : first_a;
    assign n_last      = eval ? '0 : last_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior     <= 1'b0;
            r_last_edge <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_flags     <= '0;
        end else if (i_step) begin
            r_prior     <= n_prior;
            r_last_edge <= n_last_edge;
            r_first     <= n_first;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_flags     <= n_flags;
        end
    end

endmodule

/* rtl/ubd_tone.sv */
// beep tone engine: on and off phase timing and beep countdown
`timescale 1ns / 1ps

module ubd_tone (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [ubd_pkg::TIME_W-1:0]    i_now,
    input  ubd_pkg::t_pat_req             i_req,
    output logic                          o_buzzer,
    output logic                          o_busy
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    logic [1:0]                    r_mode;
    logic [ubd_pkg::TIME_W-1:0]    r_phase;
    logic [ubd_pkg::BEEP_W-1:0]    r_beeps;
    logic [ubd_pkg::LEN_W-1:0]     r_on_len;
    logic [ubd_pkg::LEN_W-1:0]     r_off_len;
    logic                          r_buzzer;

    logic [1:0]                    n_mode;
    logic [ubd_pkg::TIME_W-1:0]    n_phase;
    logic [ubd_pkg::BEEP_W-1:0]    n_beeps;
    logic [ubd_pkg::LEN_W-1:0]     n_on_len;
    logic [ubd_pkg::LEN_W-1:0]     n_off_len;
    logic                          n_buzzer;

    logic [ubd_pkg::TIME_W-1:0]    d_phase;

    assign d_phase = i_now - r_phase;

    // phase timing, then a new pattern replaces whatever is playing
    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_beeps   = r_beeps;
        n_on_len  = r_on_len;
        n_off_len = r_off_len;
        n_buzzer  = r_buzzer;
        case (r_mode)
            MODE_ON: begin
                if (d_phase >= {{(ubd_pkg::TIME_W-ubd_pkg::LEN_W){1'b0}}, r_on_len}) begin
                    n_buzzer = 1'b0;
                    if (r_beeps <= 2'd1) begin
                        n_beeps = '0;
                        n_mode  = MODE_IDLE;
                    end else begin
                        n_beeps = r_beeps - 2'd1;
                        n_phase = i_now;
                        n_mode  = MODE_OFF;
                    end
                end
            end
            MODE_OFF: begin
                if (d_phase >= {{(ubd_pkg::TIME_W-ubd_pkg::LEN_W){1'b0}}, r_off_len}) begin
                    n_buzzer = 1'b1;
                    n_phase  = i_now;
                    n_mode   = MODE_ON;
                end
            end
            default: begin
            end
        endcase
        if (i_req.start) begin
            n_beeps   = i_req.beeps;
            n_on_len  = i_req.on_len;
            n_off_len = i_req.off_len;
            n_buzzer  = 1'b1;
            n_phase   = i_now;
            n_mode    = MODE_ON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_phase   <= '0;
            r_beeps   <= '0;
            r_on_len  <= '0;
            r_off_len <= '0;
            r_buzzer  <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_beeps   <= n_beeps;
            r_on_len  <= n_on_len;
            r_off_len <= n_off_len;
            r_buzzer  <= n_buzzer;
        end
    end

    assign o_buzzer = n_buzzer;
    assign o_busy   = (n_mode != MODE_IDLE);

    // buzzer sounds exactly in the on phase
    a_buzzer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzzer == (r_mode == MODE_ON))
        else $error("buzzer level out of step with tone phase");

    // an off phase always has a beep still to come
    a_off_beeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OFF) |-> (r_beeps != '0))
        else $error("off phase with no beeps left");

endmodule

/* rtl/unlock_pulse_burst_decoder_unit.sv */
// top level of the unlock pulse burst decoder: input register, decode logic, result register
`timescale 1ns / 1ps

//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  sample   | i_in_valid, o_in_stall, i_now_ms,         | in
//           | i_pin_level, i_monitor_enable             |
//  result   | o_out_valid, i_out_stall, o_buzzer,       | out
//           | o_tone_busy, o_lock_disabled,             |
//           | o_start_disabled, o_autostop_disabled,    |
//           | o_toggle_event                            |
//  config   | psel, penable, pwrite, paddr, pwdata,     | apb
//           | prdata, pready                            |
//
// a request waits in the input register and then moves on to the result
// register; one request per cycle while the result side does not stall
// the result register and the decoder state registers load together from one
// short compare and subtract pass over the held sample
// synchronous active-low reset clears control state and loads register defaults
// a stall on the result side holds the result; the input register still takes
// a request if it is empty, and o_in_stall rises once it holds one

module unlock_pulse_burst_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_pin_level,
    input  logic                          i_monitor_enable,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_buzzer,
    output logic                          o_tone_busy,
    output logic                          o_lock_disabled,
    output logic                          o_start_disabled,
    output logic                          o_autostop_disabled,
    output logic [1:0]                    o_toggle_event,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ubd_pkg::DATA_W-1:0]    pwdata,
    output logic [ubd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                          r_in_valid;
    logic [ubd_pkg::TIME_W-1:0]    r_now;
    logic                          r_pin;
    logic                          r_mon;

    logic                          r_out_valid;
    logic                          r_buzzer;
    logic                          r_busy;
    logic [ubd_pkg::FLAG_W-1:0]    r_flags;
    logic [ubd_pkg::EVT_W-1:0]     r_event;

    logic                          out_load;
    logic                          step;
    logic                          in_take;

    ubd_pkg::t_cfg                 cfg;
    ubd_pkg::t_pat_req             pat_req;
    logic [ubd_pkg::EVT_W-1:0]     n_event;
    logic [ubd_pkg::FLAG_W-1:0]    n_flags;
    logic                          n_buzzer;
    logic                          n_busy;

    // handshake
    assign out_load   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now <= i_now_ms;
            r_pin <= i_pin_level;
            r_mon <= i_monitor_enable;
        end
    end

    // configuration registers
    ubd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pulse and burst logic
    ubd_pulse u_pulse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .i_now   (r_now),
        .i_pin   (r_pin),
        .i_mon   (r_mon),
        .o_req   (pat_req),
        .o_event (n_event),
        .o_flags (n_flags)
    );

    // tone engine
    ubd_tone u_tone (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_now    (r_now),
        .i_req    (pat_req),
        .o_buzzer (n_buzzer),
        .o_busy   (n_busy)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_buzzer <= n_buzzer;
            r_busy   <= n_busy;
            r_flags  <= n_flags;
            r_event  <= n_event;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_buzzer            = r_buzzer;
    assign o_tone_busy         = r_busy;
    assign o_lock_disabled     = r_flags[0];
    assign o_start_disabled    = r_flags[1];
    assign o_autostop_disabled = r_flags[2];
    assign o_toggle_event      = r_event;

    // a toggle always starts a pattern in its on phase
    a_toggle_beeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_event != ubd_pkg::EVT_NONE)) |-> (r_buzzer && r_busy))
        else $error("toggle without a beep pattern starting");

    // the input side only stalls behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule
